// File: src/mdsa_pkg.sv
package mdsa_pkg;

  // Status codes of a result item
  localparam logic [1:0] StDone   = 2'd0;
  localparam logic [1:0] StFull   = 2'd1;
  localparam logic [1:0] StAbsent = 2'd2;

  // Request operations
  localparam logic OpSeat  = 1'b0;
  localparam logic OpLeave = 1'b1;

  localparam int RowLenBits = 17;
  localparam logic [RowLenBits-1:0] RowLenReset = 17'd256;

  typedef struct packed {
    logic        operation;
    logic [15:0] seat_index;
  } req_t;

  typedef struct packed {
    logic [15:0] seat;
    logic [1:0]  status;
  } rsp_t;

endpackage

// File: src/max_distance_seat_allocator.sv
// Max-distance seat allocator.
// Keeps a sorted table of occupied positions in a single-port style memory
// (one read, one write per cycle, registered read data).
// Input channel: in_valid_i / in_stall_o carry one request item (seat or
// leave). Output channel: out_valid_o / out_stall_i carry one result item
// per request. Configuration: cfg_we_i writes row_length at any edge; it
// must only be written while the block is idle.
// One request is handled at a time. Each item first scans all occupied
// entries (one memory read per cycle), then for a seat or a successful
// leave shifts table entries by one place; the memory port sets the pace.
// The result waits in an output register; while the receiver stalls, the
// block holds the result and does not finish the next item until it is
// taken. At reset the table is empty, row_length is 256 and no result is
// pending; the memory content needs no clearing.
module max_distance_seat_allocator #(
  parameter int MAX_OCCUPANTS = 256,
  parameter int POSITION_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  mdsa_pkg::req_t        in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output mdsa_pkg::rsp_t        out_data_o,
  input  logic                  cfg_we_i,
  input  logic [16:0]           cfg_wdata_i
);
  import mdsa_pkg::*;

  localparam int PB   = POSITION_BITS;
  localparam int AW   = $clog2(MAX_OCCUPANTS);
  localparam int CW   = $clog2(MAX_OCCUPANTS + 1);
  localparam int WW   = (PB + 1 > RowLenBits) ? PB + 1 : RowLenBits;
  localparam int CMPW = (CW > PB + 1) ? CW : PB + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_FIN, S_SHIFT_UP, S_SHIFT_DN, S_DONE
  } state_e;

  state_e            state_q;
  logic              op_q;
  logic [PB-1:0]     idx_q;
  logic [CW-1:0]     count_q;
  logic [CW-1:0]     addr_q;
  logic [CW-1:0]     e_q;
  logic              rv_q;
  logic [CW-1:0]     k_q;
  logic [CW-1:0]     p_q;
  logic              found_q;
  logic [PB-1:0]     left_q;
  logic [PB-1:0]     best_q;
  logic [PB-1:0]     best_dist_q;
  logic [1:0]        status_q;
  logic [RowLenBits-1:0] row_length_q;
  logic              out_valid_q;
  rsp_t              out_data_q;

  // Table memory
  logic [PB-1:0] mem [MAX_OCCUPANTS];
  logic [PB-1:0] rd_data_q;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [PB-1:0] wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Effective row length, clamped to the position span
  logic [WW-1:0] row_w, span_w, len_w;
  logic [PB:0]   len;
  logic [PB-1:0] last_pos;
  assign row_w    = WW'(row_length_q);
  assign span_w   = WW'(1) << PB;
  assign len_w    = (row_w > span_w) ? span_w : row_w;
  assign len      = len_w[PB:0];
  assign last_pos = PB'(len - (PB+1)'(1));

  logic          in_row;
  logic [PB-1:0] gap_d;
  logic          stop_dn;
  assign in_row  = {1'b0, rd_data_q} < len;
  assign gap_d   = (rd_data_q - left_q) >> 1;
  assign stop_dn = rv_q && (rd_data_q < best_q);

  logic in_acc, out_free;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    case (state_q)
      S_SCAN: begin
        if (addr_q < count_q) begin
          rd_en   = 1'b1;
          rd_addr = addr_q[AW-1:0];
        end
      end
      S_SHIFT_UP: begin
        if (rv_q) begin
          wr_en   = 1'b1;
          wr_addr = AW'(e_q - CW'(1));
          wr_data = rd_data_q;
        end
        if (addr_q < count_q) begin
          rd_en   = 1'b1;
          rd_addr = addr_q[AW-1:0];
        end
      end
      S_SHIFT_DN: begin
        if (rv_q) begin
          wr_en   = 1'b1;
          wr_addr = AW'(e_q + CW'(1));
          wr_data = stop_dn ? best_q : rd_data_q;
        end else if (addr_q == '0) begin
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_data = best_q;
        end
        if (addr_q != '0 && !stop_dn) begin
          rd_en   = 1'b1;
          rd_addr = AW'(addr_q - CW'(1));
        end
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      row_length_q <= RowLenReset;
      out_valid_q  <= 1'b0;
      rv_q         <= 1'b0;
      addr_q       <= '0;
      e_q          <= '0;
      k_q          <= '0;
      p_q          <= '0;
      found_q      <= 1'b0;
      op_q         <= OpSeat;
      idx_q        <= '0;
      left_q       <= '0;
      best_q       <= '0;
      best_dist_q  <= '0;
      status_q     <= StDone;
      out_data_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        row_length_q <= cfg_wdata_i;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            op_q        <= in_data_i.operation;
            idx_q       <= PB'(in_data_i.seat_index);
            addr_q      <= '0;
            rv_q        <= 1'b0;
            k_q         <= '0;
            found_q     <= 1'b0;
            best_q      <= '0;
            best_dist_q <= '0;
            left_q      <= '0;
            state_q     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rv_q) begin
            if (op_q == OpLeave) begin
              if (!found_q && rd_data_q == idx_q) begin
                found_q <= 1'b1;
                p_q     <= e_q;
              end
            end else if (in_row) begin
              k_q    <= k_q + CW'(1);
              left_q <= rd_data_q;
              if (k_q == '0) begin
                best_dist_q <= rd_data_q;
                best_q      <= '0;
              end else if (gap_d > best_dist_q) begin
                best_dist_q <= gap_d;
                best_q      <= left_q + gap_d;
              end
            end
          end
          if (addr_q < count_q) begin
            e_q    <= addr_q;
            addr_q <= addr_q + CW'(1);
            rv_q   <= 1'b1;
          end else begin
            rv_q <= 1'b0;
            if (!rv_q) begin
              state_q <= S_FIN;
            end
          end
        end
        S_FIN: begin
          rv_q <= 1'b0;
          if (op_q == OpLeave) begin
            best_q <= idx_q;
            if (found_q) begin
              status_q <= StDone;
              addr_q   <= p_q + CW'(1);
              state_q  <= S_SHIFT_UP;
            end else begin
              status_q <= StAbsent;
              state_q  <= S_DONE;
            end
          end else if (count_q == CW'(MAX_OCCUPANTS) || len == '0
                       || CMPW'(k_q) >= CMPW'(len)) begin
            status_q <= StFull;
            best_q   <= '0;
            state_q  <= S_DONE;
          end else begin
            status_q <= StDone;
            if (k_q == '0) begin
              best_q <= '0;
            end else if (last_pos - left_q > best_dist_q) begin
              best_q <= last_pos;
            end
            addr_q  <= count_q;
            state_q <= S_SHIFT_DN;
          end
        end
        S_SHIFT_UP: begin
          if (addr_q < count_q) begin
            e_q    <= addr_q;
            addr_q <= addr_q + CW'(1);
            rv_q   <= 1'b1;
          end else begin
            rv_q <= 1'b0;
            if (!rv_q) begin
              count_q <= count_q - CW'(1);
              state_q <= S_DONE;
            end
          end
        end
        S_SHIFT_DN: begin
          if (stop_dn || (!rv_q && addr_q == '0)) begin
            rv_q    <= 1'b0;
            count_q <= count_q + CW'(1);
            state_q <= S_DONE;
          end else if (addr_q != '0) begin
            e_q    <= addr_q - CW'(1);
            addr_q <= addr_q - CW'(1);
            rv_q   <= 1'b1;
          end else begin
            rv_q <= 1'b0;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q       <= 1'b1;
            out_data_q.seat   <= 16'(best_q);
            out_data_q.status <= status_q;
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_OCCUPANTS))
    else $error("occupant count beyond table depth");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_SCAN)
    else $error("accepted item did not start a scan");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result raised outside completion");

  a_full_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && status_q != StDone) |-> $stable(count_q))
    else $error("refused item changed occupant count");

endmodule

// File: sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mdsa_pkg::*;

  localparam int TableDepth  = 256;
  localparam int StallLimit  = 20000;
  localparam int DrainCycles = 600;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  req_t        in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  rsp_t        out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [16:0] cfg_wdata_i = '0;

  max_distance_seat_allocator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the block: sorted occupant list and row length
  logic [15:0] seated_q[$];
  logic [16:0] row_len_q = RowLenReset;

  req_t pending_q[$];
  rsp_t expected_q[$];
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   failed = 1'b0;
  bit   in_taken = 1'b0;
  int   quiet_cycles = 0;

  // Index of first occupant >= value
  function automatic int first_at_or_above(int value);
    int i;
    for (i = 0; i < seated_q.size(); i++) begin
      if (int'(seated_q[i]) >= value) return i;
    end
    return seated_q.size();
  endfunction

  // Apply one request to the shadow and return the result it yields
  function automatic rsp_t allocate_seat(req_t req);
    rsp_t rsp;
    int   len, k, p, best, best_dist, lft, rgt, mid, d, i;
    rsp.seat   = '0;
    rsp.status = StDone;
    if (req.operation == OpLeave) begin
      rsp.seat = req.seat_index;
      p = first_at_or_above(int'(req.seat_index));
      if (p < seated_q.size() && seated_q[p] == req.seat_index) begin
        seated_q.delete(p);
      end else begin
        rsp.status = StAbsent;
      end
    end else begin
      len = (int'(row_len_q) > 65536) ? 65536 : int'(row_len_q);
      k = first_at_or_above(len);
      if (seated_q.size() >= TableDepth || len == 0 || k >= len) begin
        rsp.status = StFull;
      end else if (k == 0) begin
        seated_q.push_front(16'd0);
      end else begin
        lft = int'(seated_q[0]);
        best_dist = lft;
        best = 0;
        for (i = 1; i < k; i++) begin
          rgt = int'(seated_q[i]);
          mid = lft + (rgt - lft) / 2;
          d = ((mid - lft) < (rgt - mid)) ? (mid - lft) : (rgt - mid);
          if (d > best_dist) begin
            best_dist = d;
            best = mid;
          end
          lft = rgt;
        end
        if ((len - 1 - int'(seated_q[k-1])) > best_dist) best = len - 1;
        rsp.seat = best[15:0];
        seated_q.insert(first_at_or_above(best), best[15:0]);
      end
    end
    return rsp;
  endfunction

  // Driver: new item or idle at the falling edge, hold while stalled
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
        in_valid_i <= 1'b1;
      end else if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: check results, predict accepted requests, track config, watchdog
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    bit   moved;
    moved = 1'b0;
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result seat=%0d status=%0d", $time,
                   out_data_o.seat, out_data_o.status);
          failed = 1'b1;
        end else begin
          exp_rsp = expected_q.pop_front();
          if (out_data_o.seat !== exp_rsp.seat) begin
            $display("%0t: seat mismatch expected %0d actual %0d", $time,
                     exp_rsp.seat, out_data_o.seat);
            failed = 1'b1;
          end
          if (out_data_o.status !== exp_rsp.status) begin
            $display("%0t: status mismatch expected %0d actual %0d", $time,
                     exp_rsp.status, out_data_o.status);
            failed = 1'b1;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        expected_q.push_back(allocate_seat(in_data_i));
      end
      if (cfg_we_i) row_len_q = cfg_wdata_i;
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    while (pending_q.size() > 0 || in_valid_i || expected_q.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_row_length(logic [16:0] len);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= ~len;
  endtask

  task automatic push_req(logic op, logic [15:0] idx);
    req_t r;
    r.operation  = op;
    r.seat_index = idx;
    pending_q.push_back(r);
  endtask

  // Random mix: mostly seats and leaves of occupied positions, some noise
  task automatic random_items(int count, int seat_pct);
    int n, pick;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < seat_pct) begin
        push_req(OpSeat, 16'($urandom));
      end else if (pick < 92 && seated_q.size() > 0) begin
        push_req(OpLeave, seated_q[$urandom_range(seated_q.size() - 1)]);
      end else begin
        push_req(OpLeave, 16'($urandom));
      end
      // keep generation close to the shadow so leaves mostly hit
      if (n % 8 == 7) while (pending_q.size() > 0) @(posedge clk_i);
    end
  endtask

  initial begin
    int ph;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: default row, ends, midpoint, leaves, absent leaves
    push_req(OpSeat, 16'hFFFF);
    push_req(OpSeat, 16'd0);
    push_req(OpSeat, 16'd0);
    push_req(OpSeat, 16'd0);
    push_req(OpLeave, 16'd127);
    push_req(OpLeave, 16'd127);
    push_req(OpLeave, 16'hFFFF);
    push_req(OpLeave, 16'd0);
    push_req(OpSeat, 16'd0);
    // Row shrunk below occupants: 255 stays but is outside the row
    set_row_length(17'd1);
    push_req(OpSeat, 16'd0);
    push_req(OpSeat, 16'd0);
    push_req(OpLeave, 16'd255);
    // Oversized row clamps to the position range
    set_row_length(17'h1FFFF);
    push_req(OpSeat, 16'd0);
    push_req(OpSeat, 16'd0);
    set_row_length(17'd65536);
    push_req(OpSeat, 16'd0);
    push_req(OpLeave, 16'd65535);
    push_req(OpLeave, 16'd0);
    set_row_length(17'd0);
    push_req(OpSeat, 16'd0);
    set_row_length(17'd2);
    push_req(OpSeat, 16'd0);
    push_req(OpSeat, 16'd0);
    push_req(OpSeat, 16'd0);

    // Fill the table to its depth on a wide row, then overflow it
    set_row_length(17'd65536);
    recv_stall_pct = 10;
    random_items(270, 100);
    random_items(20, 40);

    // Random phases over idling patterns and row lengths
    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      case (ph)
        0: set_row_length(17'd256);
        1: set_row_length(17'd9);
        2: set_row_length(17'd1);
        3: set_row_length(17'd65536);
        4: set_row_length(17'd40);
        5: set_row_length(17'd3);
        6: set_row_length(17'd1000);
        default: set_row_length(17'h1FFFF);
      endcase
      random_items(22, 55);
      // sender holds off until every result is back
      wait_idle();
      random_items(22, 55);
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (!failed && expected_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
